[rtl/wrm_pkg.sv]
// shared types and constants for the weighted rank record matcher
// no dependencies; used by the interfaces, controller, datapath and top level
`default_nettype none

package wrm_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 32;
    localparam int unsigned MAX_RESULTS     = 32;
    localparam int unsigned PAIR_W          = $clog2(MAX_RESULTS + 1);

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned ID_W     = 31;
    localparam int unsigned WEIGHT_W = 32;
    localparam int unsigned RANK_W   = 32;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_A       = 2'd0,
        CMD_B       = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_MATCH = 2'd0,
        STS_FULL  = 2'd1,
        STS_DONE  = 2'd2
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [ID_W-1:0]     record_id;
        logic [WEIGHT_W-1:0] record_weight;
        logic [RANK_W-1:0]   record_rank;
        logic                record_last;
    } t_rec;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id_a;
        logic [ID_W-1:0]     id_b;
        logic [WEIGHT_W-1:0] pair_weight;
        logic [RANK_W-1:0]   rank_a;
        logic [RANK_W-1:0]   rank_b;
        logic                final_pair;
    } t_res;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [WEIGHT_W-1:0] weight;
        logic [RANK_W-1:0]   rank;
        logic                last;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic emit;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic will_queue;
        logic can_match;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

[rtl/wrm_rec_if.sv]
// record channel: valid/ready handshake with the incoming record payload
// depends on wrm_pkg
`default_nettype none

interface wrm_rec_if;
    import wrm_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     record_id;
    logic [WEIGHT_W-1:0] record_weight;
    logic [RANK_W-1:0]   record_rank;
    logic                record_last;

    modport source (
        output valid, cmd, record_id, record_weight, record_rank, record_last,
        input  ready
    );
    modport sink (
        input  valid, cmd, record_id, record_weight, record_rank, record_last,
        output ready
    );
endinterface

`default_nettype wire

[rtl/wrm_res_if.sv]
// result channel: valid/ready handshake with the pair or rejection payload
// depends on wrm_pkg
`default_nettype none

interface wrm_res_if;
    import wrm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id_a;
    logic [ID_W-1:0]     id_b;
    logic [WEIGHT_W-1:0] pair_weight;
    logic [RANK_W-1:0]   rank_a;
    logic [RANK_W-1:0]   rank_b;
    logic                final_pair;

    modport source (
        output valid, status, id_a, id_b, pair_weight, rank_a, rank_b, final_pair,
        input  ready
    );
    modport sink (
        input  valid, status, id_a, id_b, pair_weight, rank_a, rank_b, final_pair,
        output ready
    );
endinterface

`default_nettype wire

[rtl/weighted_rank_record_matcher.sv]
// top level of the weighted rank record matcher: controller plus datapath
// depends on wrm_pkg, wrm_rec_if, wrm_res_if, wrm_ctrl, wrm_datapath
//
//   port     dir  modport  carries
//   i_rec    in   sink     record or restart transaction (cmd, id, weight, rank, last)
//   o_res    out  source   pair or rejection transaction (status, ids, weight, ranks, final)
//
// restart, unused cmd and rejections: taken in idle, one result for a rejection
// queued record: written in idle, then the queue heads are read in wait; each pair
// takes a compare-subtract in match, then a head read from the queue memory in wait,
// and match closes the loop once no pair can be made; at most 32 pairs per record
// reset clears counts, pointers and flags at once; queue memories need no clearing
// a stalled result holds the match loop and input acceptance until taken
`default_nettype none

module weighted_rank_record_matcher #(
    parameter int unsigned QUEUE_DEPTH = wrm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wrm_rec_if.sink   i_rec,
    wrm_res_if.source o_res
);
    import wrm_pkg::*;

    t_ctl  ctl;
    t_stat stat;
    t_rec  rec;
    t_res  res;
    logic  res_valid;

    assign rec.cmd           = i_rec.cmd;
    assign rec.record_id     = i_rec.record_id;
    assign rec.record_weight = i_rec.record_weight;
    assign rec.record_rank   = i_rec.record_rank;
    assign rec.record_last   = i_rec.record_last;

    wrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rec.valid),
        .o_in_ready (i_rec.ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    wrm_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_rec       (rec),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (o_res.ready)
    );

    assign o_res.valid       = res_valid;
    assign o_res.status      = res.status;
    assign o_res.id_a        = res.id_a;
    assign o_res.id_b        = res.id_b;
    assign o_res.pair_weight = res.pair_weight;
    assign o_res.rank_a      = res.rank_a;
    assign o_res.rank_b      = res.rank_b;
    assign o_res.final_pair  = res.final_pair;

`ifndef NO_ASSERTIONS
    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.emit |-> stat.out_free && stat.can_match)
        else $error("pair issued without room or without both heads");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctl.accept && ctl.emit))
        else $error("accept and pair issue in the same cycle");

    a_emit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.emit |=> o_res.valid && (o_res.status == STS_MATCH))
        else $error("issued pair not presented as a match");

    a_no_accept_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.emit |=> !ctl.accept)
        else $error("record accepted while heads still being fetched");
`endif

endmodule

`default_nettype wire

[rtl/wrm_ctrl.sv]
// controller: sequences record acceptance, head reads and the match loop
// depends on wrm_pkg; drives the datapath through t_ctl, watches t_stat
`default_nettype none

module wrm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire wrm_pkg::t_stat i_stat,
    output wrm_pkg::t_ctl      o_ctl
);
    import wrm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_MATCH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = (r_state == S_IDLE) && i_stat.out_free;
        case (r_state)
            S_IDLE: begin
                o_ctl.accept = o_in_ready && i_in_valid;
                if (o_ctl.accept && i_stat.will_queue) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                // head entries come out of the queue memories
                n_state = S_MATCH;
            end
            S_MATCH: begin
                if (!i_stat.can_match) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_ctl.emit = 1'b1;
                    n_state    = S_WAIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/wrm_datapath.sv]
// datapath: two record queues, head weights, compare-subtract and result register
// depends on wrm_pkg; commanded by wrm_ctrl
`default_nettype none

module wrm_datapath #(
    parameter int unsigned QUEUE_DEPTH = wrm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire wrm_pkg::t_ctl  i_ctl,
    output wrm_pkg::t_stat      o_stat,
    input  wire wrm_pkg::t_rec  i_rec,
    output wrm_pkg::t_res       o_res,
    output logic                o_res_valid,
    input  wire logic           i_res_ready
);
    import wrm_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W:0]   DEPTH_X   = (PTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [PAIR_W-1:0] PAIR_MAX = PAIR_W'(MAX_RESULTS);

    t_entry mem_a [QUEUE_DEPTH];
    t_entry mem_b [QUEUE_DEPTH];

    t_entry              r_rd_a;
    t_entry              r_rd_b;
    logic [CNT_W-1:0]    r_cnt    [2];
    logic [PTR_W-1:0]    r_head   [2];
    logic [WEIGHT_W-1:0] r_rem    [2];
    logic                r_loaded [2];
    logic                r_fin;
    logic [PAIR_W-1:0]   r_pairs;
    logic                r_out_valid;
    t_res                r_out;

    logic                is_rec;
    logic                side;
    logic                full_side;
    logic                reject;
    logic [PTR_W:0]      tail_sum;
    logic [PTR_W-1:0]    tail;
    logic [WEIGHT_W-1:0] eff_a;
    logic [WEIGHT_W-1:0] eff_b;
    logic                b_gt;
    logic [WEIGHT_W-1:0] diff;
    logic                fin_bit;
    t_entry              new_entry;

    always_comb begin
        is_rec    = (i_rec.cmd == CMD_A) || (i_rec.cmd == CMD_B);
        side      = (i_rec.cmd == CMD_B);
        full_side = (r_cnt[side] == CNT_FULL);
        reject    = is_rec && (r_fin || full_side);
        tail_sum  = (PTR_W + 1)'(r_head[side]) + (PTR_W + 1)'(r_cnt[side]);
        tail      = (tail_sum >= DEPTH_X) ? PTR_W'(tail_sum - DEPTH_X) : PTR_W'(tail_sum);

        new_entry.id     = i_rec.record_id;
        new_entry.weight = i_rec.record_weight;
        new_entry.rank   = i_rec.record_rank;
        new_entry.last   = i_rec.record_last;

        eff_a   = r_loaded[0] ? r_rem[0] : r_rd_a.weight;
        eff_b   = r_loaded[1] ? r_rem[1] : r_rd_b.weight;
        b_gt    = (eff_b > eff_a);
        diff    = b_gt ? (eff_b - eff_a) : (eff_a - eff_b);
        fin_bit = b_gt ? r_rd_a.last : r_rd_b.last;

        o_stat.will_queue = is_rec && !r_fin && !full_side;
        o_stat.can_match  = !r_fin && (r_cnt[0] != '0) && (r_cnt[1] != '0)
                            && (r_pairs < PAIR_MAX);
        o_stat.out_free   = !r_out_valid || i_res_ready;
    end

    // queue memories
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && o_stat.will_queue && !side) begin
            mem_a[tail] <= new_entry;
        end
        if (i_ctl.accept && o_stat.will_queue && side) begin
            mem_b[tail] <= new_entry;
        end
        r_rd_a <= mem_a[r_head[0]];
        r_rd_b <= mem_b[r_head[1]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '{default: '0};
            r_head      <= '{default: '0};
            r_loaded    <= '{default: 1'b0};
            r_fin       <= 1'b0;
            r_pairs     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.emit || (i_ctl.accept && reject)) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_ctl.accept) begin
                case (t_cmd'(i_rec.cmd))
                    CMD_RESTART: begin
                        r_cnt    <= '{default: '0};
                        r_head   <= '{default: '0};
                        r_loaded <= '{default: 1'b0};
                        r_fin    <= 1'b0;
                    end
                    CMD_A, CMD_B: begin
                        if (!reject) begin
                            r_cnt[side] <= r_cnt[side] + 1'b1;
                            r_pairs     <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_ctl.emit) begin
                r_pairs     <= r_pairs + 1'b1;
                if (fin_bit) begin
                    r_fin <= 1'b1;
                end
                if (b_gt) begin
                    r_head[0]   <= (r_head[0] == PTR_LAST) ? '0 : r_head[0] + 1'b1;
                    r_cnt[0]    <= r_cnt[0] - 1'b1;
                    r_loaded[0] <= 1'b0;
                    r_loaded[1] <= 1'b1;
                end else begin
                    r_head[1]   <= (r_head[1] == PTR_LAST) ? '0 : r_head[1] + 1'b1;
                    r_cnt[1]    <= r_cnt[1] - 1'b1;
                    r_loaded[1] <= 1'b0;
                    r_loaded[0] <= 1'b1;
                end
            end
        end
    end

    // result payload and remaining weights
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && reject) begin
            r_out.status      <= r_fin ? STS_DONE : STS_FULL;
            r_out.id_a        <= side ? '0 : i_rec.record_id;
            r_out.id_b        <= side ? i_rec.record_id : '0;
            r_out.pair_weight <= '0;
            r_out.rank_a      <= side ? '0 : i_rec.record_rank;
            r_out.rank_b      <= side ? i_rec.record_rank : '0;
            r_out.final_pair  <= 1'b0;
        end
        if (i_ctl.emit) begin
            r_out.status      <= STS_MATCH;
            r_out.id_a        <= r_rd_a.id;
            r_out.id_b        <= r_rd_b.id;
            r_out.pair_weight <= b_gt ? eff_a : eff_b;
            r_out.rank_a      <= r_rd_a.rank;
            r_out.rank_b      <= r_rd_b.rank;
            r_out.final_pair  <= fin_bit;
            if (b_gt) begin
                r_rem[1] <= diff;
            end else begin
                r_rem[0] <= diff;
            end
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

endmodule

`default_nettype wire
